// ----- rtl/core/dxtbd_pkg.sv -----
// ----------------------------------------------------------------------------
// dxtbd_pkg
// Shared types and codes of the DXT block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dxtbd_pkg;

  localparam int unsigned BlockDim = 4;
  localparam int unsigned NumPix   = BlockDim * BlockDim;
  localparam int unsigned PixW     = $clog2(NumPix);

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    AM_TABLE    = 2'd0,
    AM_EXPLICIT = 2'd1,
    AM_RAMP     = 2'd2
  } amode_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // One classified block as it waits between front and back.
  typedef struct packed {
    rgb_t [3:0]       pal;
    logic             three;
    amode_t           amode;
    logic [7:0][7:0]  ramp;
    logic [63:0]      ahalf;
    logic [15:0][1:0] cidx;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/dxtbd_if.sv -----
// ----------------------------------------------------------------------------
// dxtbd_if
// Valid/ready channels of the DXT block decoder: block in, pixel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dxtbd_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] alpha_half;
  logic [63:0] color_half;

  modport source (output valid, output alpha_half, output color_half, input ready);
  modport sink   (input valid, input alpha_half, input color_half, output ready);
endinterface

interface dxtbd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [1:0] pixel_col;
  logic [1:0] pixel_row;
  logic       last_pixel;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output pixel_col, output pixel_row, output last_pixel, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input pixel_col, input pixel_row, input last_pixel, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dxtbd_front.sv -----
// ----------------------------------------------------------------------------
// dxtbd_front
// Takes a block, builds its colour palette and alpha ramp, hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module dxtbd_front
  import dxtbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fmt_t        fmt,
  dxtbd_blk_if.sink   in_chan,
  output logic        ent_valid,
  output entry_t      ent,
  input  logic        ent_ready
);

  logic        blk_valid_r;
  logic [63:0] ah_r;
  logic [63:0] ch_r;

  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t e;
    e.r = {c[15:11], c[15:13]};
    e.g = {c[10:5], c[10:9]};
    e.b = {c[4:0], c[4:2]};
    return e;
  endfunction

  // floor(v/3) for v <= 765
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'd683;
    return p[18:11];
  endfunction

  // floor(v/7) for v <= 1788
  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [22:0] p;
    p = 23'(v) * 23'd2341;
    return p[21:14];
  endfunction

  // floor(v/5) for v <= 1277
  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [21:0] p;
    p = 22'(v) * 22'd1639;
    return p[20:13];
  endfunction

  function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
    return div3(10'({a, 1'b0}) + 10'(b));
  endfunction

  function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b);
    return s[8:1];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      blk_valid_r <= 1'b1;
    end else if (ent_ready) begin
      blk_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      ah_r <= in_chan.alpha_half;
      ch_r <= in_chan.color_half;
    end
  end

  assign in_chan.ready = !blk_valid_r || ent_ready;
  assign ent_valid     = blk_valid_r;

  always_comb begin
    rgb_t       e0;
    rgb_t       e1;
    logic [7:0] a0;
    logic [7:0] a1;
    logic       four;
    e0 = expand565(ch_r[15:0]);
    e1 = expand565(ch_r[31:16]);
    a0 = ah_r[7:0];
    a1 = ah_r[15:8];

    unique case (fmt) inside
      FMT_DXT3: ent.amode = AM_EXPLICIT;
      FMT_DXT5: ent.amode = AM_RAMP;
      FMT_DXT1, FMT_RSVD: ent.amode = AM_TABLE;
      default: ent.amode = AM_TABLE;
    endcase

    four = (ch_r[15:0] > ch_r[31:16]) || (ent.amode != AM_TABLE);
    ent.three  = !four;
    ent.pal[0] = e0;
    ent.pal[1] = e1;
    if (four) begin
      ent.pal[2] = '{r: third(e0.r, e1.r), g: third(e0.g, e1.g), b: third(e0.b, e1.b)};
      ent.pal[3] = '{r: third(e1.r, e0.r), g: third(e1.g, e0.g), b: third(e1.b, e0.b)};
    end else begin
      ent.pal[2] = '{r: half(e0.r, e1.r), g: half(e0.g, e1.g), b: half(e0.b, e1.b)};
      ent.pal[3] = '0;
    end

    ent.ramp[0] = a0;
    ent.ramp[1] = a1;
    if (a0 > a1) begin
      for (int i = 0; i < 6; i++) begin
        ent.ramp[i + 2] = div7(11'(6 - i) * 11'(a0) + 11'(1 + i) * 11'(a1) + 11'd3);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        ent.ramp[i + 2] = div5(11'(4 - i) * 11'(a0) + 11'(1 + i) * 11'(a1) + 11'd2);
      end
      ent.ramp[6] = 8'h00;
      ent.ramp[7] = 8'hFF;
    end

    ent.ahalf = ah_r;
    ent.cidx  = ch_r[63:32];
  end

endmodule

`default_nettype wire

// ----- rtl/core/dxtbd_queue.sv -----
// ----------------------------------------------------------------------------
// dxtbd_queue
// Short FIFO of classified blocks between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dxtbd_queue
  import dxtbd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  entry_t push_data,
  output logic   push_ready,
  output logic   pop_valid,
  output entry_t pop_data,
  input  logic   pop_ready
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [CntW-1:0]   cnt_r;
  logic              push;
  logic              pop;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign push_ready = (cnt_r != CntW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dxtbd_back.sv -----
// ----------------------------------------------------------------------------
// dxtbd_back
// Walks the sixteen pixels of the head block into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dxtbd_back
  import dxtbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ent_valid,
  input  entry_t      ent,
  output logic        ent_ready,
  dxtbd_pix_if.source out_chan
);

  logic [PixW-1:0]  cnt_r;
  logic             ov_r;
  rgb_t             rgb_r;
  logic [7:0]       alpha_r;
  logic [PixW-1:0]  pos_r;
  logic             last_r;

  logic             load;
  logic             last;
  logic [1:0]       sel;
  logic [15:0][3:0] nibs;
  logic [15:0][2:0] ridx;
  logic [3:0]       nib;
  logic [7:0]       alpha_nxt;

  assign load      = ent_valid && (!ov_r || out_chan.ready);
  assign last      = (cnt_r == PixW'(NumPix - 1));
  assign ent_ready = load && last;

  assign sel  = ent.cidx[cnt_r];
  assign nibs = ent.ahalf;
  assign ridx = ent.ahalf[63:16];
  assign nib  = nibs[cnt_r];

  always_comb begin
    case (ent.amode)
      AM_EXPLICIT: alpha_nxt = {nib, nib};
      AM_RAMP:     alpha_nxt = ent.ramp[ridx[cnt_r]];
      default:     alpha_nxt = (ent.three && (sel == 2'd3)) ? 8'h00 : 8'hFF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else if (load) begin
      cnt_r <= cnt_r + PixW'(1);
      ov_r  <= 1'b1;
    end else if (out_chan.ready) begin
      ov_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rgb_r   <= ent.pal[sel];
      alpha_r <= alpha_nxt;
      pos_r   <= cnt_r;
      last_r  <= last;
    end
  end

  assign out_chan.valid      = ov_r;
  assign out_chan.red        = rgb_r.r;
  assign out_chan.green      = rgb_r.g;
  assign out_chan.blue       = rgb_r.b;
  assign out_chan.alpha      = alpha_r;
  assign out_chan.pixel_col  = pos_r[1:0];
  assign out_chan.pixel_row  = pos_r[3:2];
  assign out_chan.last_pixel = last_r;

endmodule

`default_nettype wire

// ----- rtl/core/dxt_block_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// dxt_block_decoder_unit
// DXT1/DXT3/DXT5 4x4 block decoder with an APB format register.
// ----------------------------------------------------------------------------
// A block is taken as two 64-bit halves and comes out as sixteen RGBA8888
// pixels in row order, one per cycle while the output is ready, the
// sixteenth marked last. The pixel output carries one pixel a transfer. A
// new block is taken while the previous one is still being emitted: the
// front stage registers the block, builds its palette and alpha ramp from
// that register and parks it in a QUEUE_DEPTH-entry queue. The block passes
// the front register, the queue and the output register before its first
// pixel is valid. block_format (byte address 0) must only be written while
// no block is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt_block_decoder_unit
  import dxtbd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  dxtbd_blk_if.sink    in_chan,
  dxtbd_pix_if.source  out_chan
);

  fmt_t   fmt_r;
  logic   f_valid;
  entry_t f_ent;
  logic   f_ready;
  logic   b_valid;
  entry_t b_ent;
  logic   b_ready;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {30'd0, fmt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_DXT1;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      fmt_r <= fmt_t'(pwdata[1:0]);
    end
  end

  dxtbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (fmt_r),
    .in_chan   (in_chan),
    .ent_valid (f_valid),
    .ent       (f_ent),
    .ent_ready (f_ready)
  );

  dxtbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_data  (f_ent),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_data   (b_ent),
    .pop_ready  (b_ready)
  );

  dxtbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (b_valid),
    .ent       (b_ent),
    .ent_ready (b_ready),
    .out_chan  (out_chan)
  );

`ifndef SYNTHESIS
  a_block_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !out_chan.last_pixel) |=> out_chan.valid)
    else $error("pixel stream of a block broke off");

  a_pixel_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !out_chan.last_pixel) |=>
      ({out_chan.pixel_row, out_chan.pixel_col} ==
       $past({out_chan.pixel_row, out_chan.pixel_col}) + 4'd1))
    else $error("pixel position out of order");

  a_dxt1_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && fmt_r == FMT_DXT1) |->
      (out_chan.alpha == 8'h00 || out_chan.alpha == 8'hFF))
    else $error("DXT1 alpha not binary");

  a_dxt1_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && fmt_r == FMT_DXT1 && out_chan.alpha == 8'h00) |->
      (out_chan.red == 8'h00 && out_chan.green == 8'h00 && out_chan.blue == 8'h00))
    else $error("DXT1 transparent pixel not black");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_dxt_block_decoder_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dxt_block_decoder_unit
// Self-checking bench for the DXT1/DXT3/DXT5 block decoder.
// ----------------------------------------------------------------------------
// Compressed blocks are fed on the block channel from a queue. Every block
// transfer is decoded by a local model into sixteen expected pixels, and each
// pixel transfer on the output channel is checked against the oldest one.
// Both channels idle at random. The format register is changed between
// phases only when the decoder is empty and is read back after each write.
// ----------------------------------------------------------------------------

module tb_dxt_block_decoder_unit;
  import dxtbd_pkg::*;

  localparam logic [2:0] ADDR_FORMAT = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  typedef struct {
    logic [63:0] ah;
    logic [63:0] ch;
  } block_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] col;
    logic [1:0] row;
    logic       last;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dxtbd_blk_if blk_if ();
  dxtbd_pix_if pix_if ();

  dxt_block_decoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_chan  (blk_if),
    .out_chan (pix_if)
  );

  block_t pending_blocks[$];
  pixel_t pending_pixels[$];
  fmt_t   cur_fmt;
  logic   burst_mode;
  int     err_count;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic rgb_t widen565(input logic [15:0] c);
    rgb_t o;
    o.r = {c[15:11], c[15:13]};
    o.g = {c[10:5], c[10:9]};
    o.b = {c[4:0], c[4:2]};
    return o;
  endfunction

  // Expected pixels of one block under the given format.
  function automatic void decode_block(input logic [63:0] ah, input logic [63:0] ch,
                                       input fmt_t fmt);
    rgb_t        e0, e1;
    logic [7:0]  e0c[3], e1c[3];
    logic [7:0]  pal[4][3];
    logic [7:0]  pal_a[4];
    logic [7:0]  ramp[8];
    int unsigned s0, s1, a0, a1;
    logic        four;
    logic [1:0]  sel;
    pixel_t      px;
    int          n;
    e0 = widen565(ch[15:0]);
    e1 = widen565(ch[31:16]);
    e0c = '{e0.r, e0.g, e0.b};
    e1c = '{e1.r, e1.g, e1.b};
    four = (ch[15:0] > ch[31:16]) || (fmt == FMT_DXT3) || (fmt == FMT_DXT5);
    for (int k = 0; k < 3; k++) begin
      s0 = e0c[k];
      s1 = e1c[k];
      pal[0][k] = e0c[k];
      pal[1][k] = e1c[k];
      if (four) begin
        pal[2][k] = 8'((2 * s0 + s1) / 3);
        pal[3][k] = 8'((s0 + 2 * s1) / 3);
      end else begin
        pal[2][k] = 8'((s0 + s1) / 2);
        pal[3][k] = 8'd0;
      end
    end
    pal_a = '{8'hFF, 8'hFF, 8'hFF, four ? 8'hFF : 8'h00};

    a0 = ah[7:0];
    a1 = ah[15:8];
    ramp[0] = ah[7:0];
    ramp[1] = ah[15:8];
    if (a0 > a1) begin
      for (int i = 0; i < 6; i++)
        ramp[i + 2] = 8'(((6 - i) * a0 + (1 + i) * a1 + 3) / 7);
    end else begin
      for (int i = 0; i < 4; i++)
        ramp[i + 2] = 8'(((4 - i) * a0 + (1 + i) * a1 + 2) / 5);
      ramp[6] = 8'h00;
      ramp[7] = 8'hFF;
    end

    n = 0;
    for (int y = 0; y < BlockDim; y++) begin
      for (int x = 0; x < BlockDim; x++) begin
        sel = ch[32 + 8 * y + 2 * x +: 2];
        px.red   = pal[sel][0];
        px.green = pal[sel][1];
        px.blue  = pal[sel][2];
        if (fmt == FMT_DXT3)
          px.alpha = 8'(ah[16 * y + 4 * x +: 4] * 17);
        else if (fmt == FMT_DXT5)
          px.alpha = ramp[ah[16 + 12 * y + 3 * x +: 3]];
        else
          px.alpha = pal_a[sel];
        px.col  = 2'(x);
        px.row  = 2'(y);
        px.last = (n == NumPix - 1);
        pending_pixels.push_back(px);
        n++;
      end
    end
  endfunction

  function automatic void push_block(input logic [63:0] ah, input logic [63:0] ch);
    block_t b;
    b.ah = ah;
    b.ch = ch;
    pending_blocks.push_back(b);
  endfunction

  // Random block, biased toward the three-colour and six-level cases.
  function automatic void push_random_block();
    logic [63:0] ah, ch;
    logic [15:0] t;
    logic [7:0]  u;
    ah = {$urandom, $urandom};
    ch = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0 && ch[15:0] > ch[31:16]) begin
      t = ch[15:0];
      ch[15:0] = ch[31:16];
      ch[31:16] = t;
    end
    if ($urandom_range(0, 7) == 0) ch[31:16] = ch[15:0];
    if ($urandom_range(0, 1) == 0 && ah[7:0] > ah[15:8]) begin
      u = ah[7:0];
      ah[7:0] = ah[15:8];
      ah[15:8] = u;
    end
    if ($urandom_range(0, 7) == 0) ah[15:8] = ah[7:0];
    push_block(ah, ch);
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Register write followed by a read-back of the format register.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_FORMAT) cur_fmt = fmt_t'(data[1:0]);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= ADDR_FORMAT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {30'd0, cur_fmt}) begin
      $display("%0t: block_format readback mismatch: expected %0d, actual %0d",
               $time, cur_fmt, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_blocks.size() != 0 || blk_if.valid || pending_pixels.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Block driver
  always @(posedge clk) begin : blk_drv
    int   in_gap;
    logic hold;
    if (!rst_n) begin
      blk_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (blk_if.valid && blk_if.ready) begin
        decode_block(pending_blocks[0].ah, pending_blocks[0].ch, cur_fmt);
        void'(pending_blocks.pop_front());
        in_gap = burst_mode ? 0 : pick_gap();
      end
      hold = blk_if.valid && !blk_if.ready;
      if (!hold) begin
        if (in_gap > 0) begin
          in_gap--;
          blk_if.valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          blk_if.valid      <= 1'b1;
          blk_if.alpha_half <= pending_blocks[0].ah;
          blk_if.color_half <= pending_blocks[0].ch;
        end else begin
          blk_if.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor
  always @(posedge clk) begin : pix_mon
    int     out_stall;
    pixel_t e;
    if (!rst_n) begin
      pix_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel transfer: expected none, actual r=%0d g=%0d b=%0d a=%0d",
                   $time, pix_if.red, pix_if.green, pix_if.blue, pix_if.alpha);
          err_count++;
        end else begin
          e = pending_pixels.pop_front();
          check_field("red", e.red, pix_if.red);
          check_field("green", e.green, pix_if.green);
          check_field("blue", e.blue, pix_if.blue);
          check_field("alpha", e.alpha, pix_if.alpha);
          check_field("pixel_col", 8'(e.col), 8'(pix_if.pixel_col));
          check_field("pixel_row", 8'(e.row), 8'(pix_if.pixel_row));
          check_field("last_pixel", 8'(e.last), 8'(pix_if.last_pixel));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= 1'b1;
        if (!burst_mode && $urandom_range(0, 3) == 0) out_stall = pick_gap();
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [47:0] ramp_idx;
    logic [31:0] wdata;
    fmt_t        f;
    err_count  = 0;
    burst_mode = 1'b0;
    cur_fmt    = FMT_DXT1;
    rst_n      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    for (int n = 0; n < NumPix; n++) ramp_idx[3 * n +: 3] = 3'(n % 8);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // DXT1 from reset: four-colour, three-colour with transparent, equal endpoints
    push_block(64'd0, {32'hE4E4_E4E4, 16'h0000, 16'hFFFF});
    push_block({64{1'b1}}, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
    push_block({$urandom, $urandom}, {32'h1B1B_1B1B, 16'h7BEF, 16'h7BEF});
    push_block(64'd0, 64'd0);
    push_block({64{1'b1}}, {64{1'b1}});
    push_block(64'd0, {$urandom, 16'h07E0, 16'hF800});
    push_block(64'd0, {$urandom, 16'hF800, 16'h001F});
    wait_idle();

    // DXT3: low endpoint first still gives four colours
    apb_write(ADDR_FORMAT, {30'd0, FMT_DXT3});
    @(negedge clk);
    push_block(64'hFEDC_BA98_7654_3210, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
    push_block(64'd0, {64{1'b1}});
    push_block({64{1'b1}}, {$urandom, $urandom});
    push_block({$urandom, $urandom}, {$urandom, 16'hF000, 16'h0F00});
    wait_idle();

    // DXT5: eight-level, six-level and flat ramps
    apb_write(ADDR_FORMAT, {30'd0, FMT_DXT5});
    @(negedge clk);
    push_block({ramp_idx, 8'h00, 8'hFF}, {32'hE4E4_E4E4, 16'h0000, 16'hFFFF});
    push_block({ramp_idx, 8'hFF, 8'h00}, {$urandom, $urandom});
    push_block({ramp_idx, 8'h80, 8'h80}, {$urandom, $urandom});
    push_block({$urandom, 16'd0, 8'hF0, 8'h10}, {$urandom, $urandom});
    push_block({$urandom, 16'd0, 8'h10, 8'hF0}, {$urandom, $urandom});
    push_block({64{1'b1}}, 64'd0);
    push_block(64'd0, {64{1'b1}});
    wait_idle();

    // Reserved code acts as DXT1; write to an unused address is dropped
    apb_write(ADDR_FORMAT, {30'h3FFF_FFFF, FMT_RSVD});
    apb_write(ADDR_UNUSED, 32'h0000_0001);
    @(negedge clk);
    push_block({64{1'b1}}, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
    push_block({$urandom, $urandom}, {$urandom, $urandom});
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      f = fmt_t'($urandom_range(0, 3));
      wdata = $urandom;
      wdata[1:0] = f;
      apb_write(ADDR_FORMAT, wdata);
      burst_mode = (p == 2) || (p == 5);
      @(negedge clk);
      for (int i = 0; i < 12; i++) push_random_block();
      wait_idle();
    end

    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- dxt_block_decoder_unit.f -----
rtl/core/dxtbd_pkg.sv
rtl/core/dxtbd_if.sv
rtl/core/dxtbd_front.sv
rtl/core/dxtbd_queue.sv
rtl/core/dxtbd_back.sv
rtl/core/dxt_block_decoder_unit.sv
tb/tb_dxt_block_decoder_unit.sv
